FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/core/rpdm_pkg.sv
// Package for the parity disk map: constants, codes and shared types.
package rpdm_pkg;

   localparam int MAX_DISKS   = 32;
   localparam int DISK_W      = $clog2(MAX_DISKS);
   localparam int N_W         = DISK_W + 1;
   localparam int SUM_W       = N_W + 1;
   localparam int OFFSET_W    = 64;
   localparam int SECTOR_BYTES = 512;
   localparam int SECT_SHIFT  = $clog2(SECTOR_BYTES);
   localparam int QUOT_W      = OFFSET_W - SECT_SHIFT;
   localparam int CHUNK_W     = 17;
   localparam int W_W         = DISK_W + CHUNK_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = CHUNK_W;

   localparam logic [N_W-1:0]     RST_DISKS = N_W'(4);
   localparam logic [CHUNK_W-1:0] RST_CHUNK = CHUNK_W'(128);

   typedef enum logic [1:0] {
      LVL_RAID4 = 2'd0,
      LVL_RAID5 = 2'd1,
      LVL_RAID6 = 2'd2,
      LVL_OTHER = 2'd3
   } lvl_type;

   typedef enum logic [1:0] {
      LAY_LEFT_ASYM  = 2'd0,
      LAY_RIGHT_ASYM = 2'd1,
      LAY_LEFT_SYM   = 2'd2,
      LAY_RIGHT_SYM  = 2'd3
   } lay_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL  = 2'd0,
      CSR_LAYOUT = 2'd1,
      CSR_DISKS  = 2'd2,
      CSR_CHUNK  = 2'd3
   } csr_idx_type;

   // Derived configuration, held in one register.
   typedef struct packed {
      lvl_type          level;
      logic             asym;
      logic             right;
      logic [N_W-1:0]   n;
      logic [W_W-1:0]   w;
      logic             bad;
   } cfg_type;

   // Divider beat handed to the mapping stages.
   typedef struct packed {
      logic [DISK_W-1:0] qm;
      logic [DISK_W-1:0] dm;
      logic [DISK_W-1:0] d;
   } div_beat_type;

endpackage

FILE: rtl/core/rpdm_cfg.sv
// Configuration registers and the derived row width and disk count.
module rpdm_cfg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rpdm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpdm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rpdm_pkg::cfg_type                 cfg,
   output logic                              busy
);
   import rpdm_pkg::*;

   lvl_type              level_ff;
   lay_type              layout_ff;
   logic [N_W-1:0]       disks_ff;
   logic [CHUNK_W-1:0]   chunk_ff;
   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 pend_ff;
   logic [N_W-1:0]       n_sat;
   logic [N_W-1:0]       spare;
   logic [N_W-1:0]       ddisk;
   logic                 striped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LVL_RAID5;
         layout_ff <= LAY_LEFT_ASYM;
         disks_ff  <= RST_DISKS;
         chunk_ff  <= RST_CHUNK;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_LEVEL:  level_ff  <= lvl_type'(csr_wdata[1:0]);
            CSR_LAYOUT: layout_ff <= lay_type'(csr_wdata[1:0]);
            CSR_DISKS:  disks_ff  <= csr_wdata[N_W-1:0];
            CSR_CHUNK:  chunk_ff  <= csr_wdata[CHUNK_W-1:0];
            default: ;
         endcase
      end
   end

   // derived config follows the registers in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b1;
      end else begin
         pend_ff <= csr_valid && csr_ready;
      end
   end

   always_comb begin
      n_sat   = (disks_ff > N_W'(MAX_DISKS)) ? N_W'(MAX_DISKS) : disks_ff;
      striped = (level_ff == LVL_RAID5) || (level_ff == LVL_RAID6);
      spare   = (level_ff == LVL_RAID6) ? N_W'(2) : N_W'(1);
      ddisk   = n_sat - spare;
      cfg_in.level = level_ff;
      cfg_in.asym  = (layout_ff == LAY_LEFT_ASYM) || (layout_ff == LAY_RIGHT_ASYM);
      cfg_in.right = (layout_ff == LAY_RIGHT_ASYM) || (layout_ff == LAY_RIGHT_SYM);
      cfg_in.n     = n_sat;
      cfg_in.w     = W_W'(ddisk[DISK_W-1:0]) * W_W'(chunk_ff);
      cfg_in.bad   = (n_sat == '0) ||
                     (striped && ((n_sat <= spare) || (chunk_ff == '0)));
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg  = cfg_ff;
   assign busy = pend_ff;

endmodule

FILE: rtl/core/rpdm_div.sv
// Restoring divider pipeline: row number modulo disk count, one quotient bit per stage.
module rpdm_div (
   input  logic                              clock,
   input  logic                              reset,
   input  rpdm_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [rpdm_pkg::QUOT_W-1:0]       in_offset,
   input  logic [rpdm_pkg::DISK_W-1:0]       in_d,
   output logic                              out_valid,
   input  logic                              out_ready,
   output rpdm_pkg::div_beat_type            out_beat
);
   import rpdm_pkg::*;

   logic                vld_ff [QUOT_W];
   logic [W_W-1:0]      rem_ff [QUOT_W];
   logic [W_W-1:0]      rem_in [QUOT_W];
   logic [QUOT_W-1:0]   dvd_ff [QUOT_W];
   logic [QUOT_W-1:0]   dvd_in [QUOT_W];
   logic [DISK_W-1:0]   qm_ff  [QUOT_W];
   logic [DISK_W-1:0]   qm_in  [QUOT_W];
   logic [DISK_W-1:0]   dm_ff  [QUOT_W];
   logic [DISK_W-1:0]   dm_in  [QUOT_W];
   logic [DISK_W-1:0]   d_ff   [QUOT_W];
   logic                rdy    [QUOT_W+1];

   assign rdy[QUOT_W] = out_ready;
   assign in_ready    = rdy[0];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic                pv;
      logic [W_W-1:0]      prem;
      logic [QUOT_W-1:0]   pdvd;
      logic [DISK_W-1:0]   pqm;
      logic [DISK_W-1:0]   pdm;
      logic [DISK_W-1:0]   pd;
      logic [W_W:0]        trial;
      logic                qb;
      logic [DISK_W:0]     qm2;

      if (k == 0) begin : g_first
         assign pv   = in_valid;
         assign prem = '0;
         assign pdvd = in_offset;
         assign pqm  = '0;
         assign pdm  = '0;
         assign pd   = in_d;
      end else begin : g_next
         assign pv   = vld_ff[k-1];
         assign prem = rem_ff[k-1];
         assign pdvd = dvd_ff[k-1];
         assign pqm  = qm_ff[k-1];
         assign pdm  = dm_ff[k-1];
         assign pd   = d_ff[k-1];
      end

      assign rdy[k] = !vld_ff[k] || rdy[k+1];

      always_comb begin
         trial     = {prem, pdvd[QUOT_W-1]};
         qb        = trial >= {1'b0, cfg.w};
         rem_in[k] = qb ? W_W'(trial - {1'b0, cfg.w}) : trial[W_W-1:0];
         dvd_in[k] = pdvd << 1;
         qm2       = {pqm, qb};
         qm_in[k]  = (qm2 >= cfg.n) ? DISK_W'(qm2 - cfg.n) : qm2[DISK_W-1:0];
      end

      // data index reduced modulo n over the first stages
      if (k < DISK_W) begin : g_dmod
         logic [DISK_W:0] dm2;
         assign dm2      = {pdm, pd[DISK_W-1-k]};
         assign dm_in[k] = (dm2 >= cfg.n) ? DISK_W'(dm2 - cfg.n) : dm2[DISK_W-1:0];
      end else begin : g_dpass
         assign dm_in[k] = pdm;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && pv) begin
            rem_ff[k] <= rem_in[k];
            dvd_ff[k] <= dvd_in[k];
            qm_ff[k]  <= qm_in[k];
            dm_ff[k]  <= dm_in[k];
            d_ff[k]   <= pd;
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W-1];

   always_comb begin
      out_beat.qm = qm_ff[QUOT_W-1];
      out_beat.dm = dm_ff[QUOT_W-1];
      out_beat.d  = d_ff[QUOT_W-1];
   end

endmodule

FILE: rtl/core/rpdm_map.sv
// Layout stages: parity disk, then physical disk and the output register.
module rpdm_map (
   input  logic                              clock,
   input  logic                              reset,
   input  rpdm_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  rpdm_pkg::div_beat_type            in_beat,
   output logic                              out_valid,
   input  logic                              out_stall,
   output logic [rpdm_pkg::DISK_W-1:0]       out_parity,
   output logic [rpdm_pkg::DISK_W-1:0]       out_phys,
   output logic                              out_bad
);
   import rpdm_pkg::*;

   logic                a_vld_ff;
   logic [DISK_W-1:0]   a_par_ff;
   logic [DISK_W-1:0]   a_par_in;
   logic [SUM_W-1:0]    a_sum_ff;
   logic [SUM_W-1:0]    a_sum_in;
   logic [DISK_W-1:0]   a_d_ff;
   logic                b_vld_ff;
   logic [DISK_W-1:0]   b_par_ff;
   logic [DISK_W-1:0]   b_phys_ff;
   logic [DISK_W-1:0]   b_phys_in;
   logic                b_bad_ff;
   logic                rdy_a;
   logic                rdy_b;
   logic [N_W-1:0]      par_n;
   logic [SUM_W-1:0]    sum;
   logic [SUM_W-1:0]    sum2;
   logic                q_zero;
   logic                ge;
   logic [DISK_W-1:0]   r6_asym;
   logic [DISK_W-1:0]   r5_asym;

   assign rdy_b    = !b_vld_ff || !out_stall;
   assign rdy_a    = !a_vld_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage A: parity disk and first reduction of the rotated index
   always_comb begin
      case (cfg.level)
         LVL_RAID5, LVL_RAID6: begin
            par_n = cfg.right ? N_W'(in_beat.qm)
                              : cfg.n - N_W'(1) - N_W'(in_beat.qm);
         end
         LVL_RAID4: par_n = cfg.n - N_W'(1);
         default:   par_n = '0;
      endcase
      a_par_in = par_n[DISK_W-1:0];
      sum      = SUM_W'(a_par_in) + SUM_W'(in_beat.dm) +
                 ((cfg.level == LVL_RAID6) ? SUM_W'(2) : SUM_W'(1));
      a_sum_in = (sum >= SUM_W'(cfg.n)) ? sum - SUM_W'(cfg.n) : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (rdy_a) begin
         a_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         a_par_ff <= a_par_in;
         a_sum_ff <= a_sum_in;
         a_d_ff   <= in_beat.d;
      end
   end

   // stage B: physical disk
   always_comb begin
      sum2    = (a_sum_ff >= SUM_W'(cfg.n)) ? a_sum_ff - SUM_W'(cfg.n) : a_sum_ff;
      q_zero  = (N_W'(a_par_ff) + N_W'(1)) == cfg.n;
      ge      = a_d_ff >= a_par_ff;
      r6_asym = a_d_ff + (q_zero ? DISK_W'(1) : (ge ? DISK_W'(2) : DISK_W'(0)));
      r5_asym = a_d_ff + DISK_W'(ge);
      if (cfg.level == LVL_RAID6) begin
         b_phys_in = cfg.asym ? r6_asym : sum2[DISK_W-1:0];
      end else if ((cfg.level == LVL_RAID5) && cfg.asym) begin
         b_phys_in = r5_asym;
      end else begin
         b_phys_in = sum2[DISK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (rdy_b) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b && a_vld_ff) begin
         b_par_ff  <= cfg.bad ? '0 : a_par_ff;
         b_phys_ff <= cfg.bad ? '0 : b_phys_in;
         b_bad_ff  <= cfg.bad;
      end
   end

   assign out_valid  = b_vld_ff;
   assign out_parity = b_par_ff;
   assign out_phys   = b_phys_ff;
   assign out_bad    = b_bad_ff;

endmodule

FILE: rtl/core/raid_parity_disk_map.sv
// Top level of the RAID4/5/6 parity and data disk map.
// Takes one beat per cycle while req_stall is low and returns one result per
// beat, in order. The block has 57 register stages. The divider produces the
// row number (offset over 512 bytes, over data disks times chunk sectors) one
// quotient bit per stage over 55 stages, with the row modulo disk count folded
// in bit by bit; two layout stages follow, the last one being the output
// register. Empty stages are filled while the result side stalls. The input
// stalls after reset and after each register write, while the derived
// configuration settles.
module raid_parity_disk_map (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rpdm_pkg::OFFSET_W-1:0]     req_byte_offset,
   input  logic [rpdm_pkg::DISK_W-1:0]       req_data_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rpdm_pkg::DISK_W-1:0]       rsp_parity_disk,
   output logic [rpdm_pkg::DISK_W-1:0]       rsp_physical_disk,
   output logic                              rsp_invalid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rpdm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpdm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rpdm_pkg::*;

   cfg_type        cfg;
   logic           cfg_busy;
   logic           div_in_ready;
   logic           div_valid;
   logic           map_ready;
   div_beat_type   div_beat;

   rpdm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (cfg_busy)
   );

   rpdm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid && !cfg_busy),
      .in_ready  (div_in_ready),
      .in_offset (req_byte_offset[OFFSET_W-1:SECT_SHIFT]),
      .in_d      (req_data_index),
      .out_valid (div_valid),
      .out_ready (map_ready),
      .out_beat  (div_beat)
   );

   rpdm_map u_map (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (div_valid),
      .in_ready   (map_ready),
      .in_beat    (div_beat),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_parity (rsp_parity_disk),
      .out_phys   (rsp_physical_disk),
      .out_bad    (rsp_invalid)
   );

   assign req_stall = !div_in_ready || cfg_busy;

endmodule

FILE: rtl/core/rpdm_checker.sv
// Port-level checks for the parity disk map, bound to the top level.
`include "assert_macros.svh"

module rpdm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [4:0]   rsp_parity_disk,
   input logic [4:0]   rsp_physical_disk,
   input logic         rsp_invalid,
   input logic         csr_valid,
   input logic         csr_ready
);

   `ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid,
               rsp_parity_disk == 5'd0 && rsp_physical_disk == 5'd0)
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
               rsp_valid && $stable(rsp_parity_disk) &&
               $stable(rsp_physical_disk) && $stable(rsp_invalid))
   `ASSERT_NXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_IMP(a_stall_source, clock, reset, req_stall,
               (rsp_valid && rsp_stall) || $past(csr_valid && csr_ready) || $past(reset))

endmodule

bind raid_parity_disk_map rpdm_checker u_rpdm_checker (.*);
